>>> design/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg: shared types and constants of the merge sorter
// Store depth, key width, the queue entry passed from front to back, and
// the helpers that move keys between port width and internal width.
// ----------------------------------------------------------------------------
package ms_pkg;

  localparam int MAX_KEYS    = 64;                    // store depth, 2..64
  localparam int KEY_BITS    = 16;                    // internal key width, 4..32
  localparam int IN_BITS     = 16;                    // key_value port width
  localparam int OUT_BITS    = 16;                    // sorted_key port width
  localparam int ADDR_W      = $clog2(MAX_KEYS);
  localparam int CNT_W       = $clog2(MAX_KEYS + 1);
  localparam int SPAN_W      = CNT_W + 2;             // holds lo + 2*width
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [SPAN_W-1:0]   span_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  localparam cnt_t MAX_CNT = CNT_W'(MAX_KEYS);

  // one classified item on its way to the back end
  typedef struct packed {
    key_t key;
    logic store;    // key goes into the store at slot cnt-1
    cnt_t cnt;      // keys held in the run, this one included
    logic last;     // closes the run
    logic dropped;  // run has lost a key so far
  } entry_t;

  function automatic key_t take_key(logic [IN_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[KEY_BITS-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] give_key(key_t k);
    logic [31:0] wide;
    wide = 32'(k);
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

>>> design/ms_front.sv
// ----------------------------------------------------------------------------
// ms_front: input side of the merge sorter
// Counts keys of the open run, marks overflow and tags each item with its
// store slot before handing it to the queue.
// ----------------------------------------------------------------------------
module ms_front
  import ms_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           key_valid,
  output logic           key_ready,
  input  logic [IN_BITS-1:0] key_value,
  input  logic           run_end,
  output logic           push_valid,
  input  logic           push_ready,
  output entry_t         push_entry
);

  cnt_t cnt;
  logic ovf;
  cnt_t cnt_next;
  logic store;

  always_comb begin
    store    = (cnt != MAX_CNT);
    cnt_next = store ? cnt + CNT_W'(1) : cnt;
    push_entry.key     = take_key(key_value);
    push_entry.store   = store;
    push_entry.cnt     = cnt_next;
    push_entry.last    = run_end;
    push_entry.dropped = ovf | ~store;
  end

  assign push_valid = key_valid;
  assign key_ready  = push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (key_valid && key_ready) begin
      if (run_end) begin
        cnt <= '0;
        ovf <= 1'b0;
      end else begin
        cnt <= cnt_next;
        ovf <= push_entry.dropped;
      end
    end
  end

  // run count saturates at the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MAX_CNT)
    else $error("front key count beyond store depth");

endmodule

>>> design/ms_queue.sv
// ----------------------------------------------------------------------------
// ms_queue: short item queue between front and back
// Small register FIFO so that loading and sorting stall independently.
// ----------------------------------------------------------------------------
module ms_queue
  import ms_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  entry_t                slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       fill;
  logic                  push;
  logic                  pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

endmodule

>>> design/ms_back.sv
// ----------------------------------------------------------------------------
// ms_back: store, bottom-up merge engine and result stage
// Loads keys into one bank, merges runs of doubling width between two banks
// one key per cycle, then streams the sorted bank to the output register.
// ----------------------------------------------------------------------------
module ms_back
  import ms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  entry_t              q_entry,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [OUT_BITS-1:0] sorted_key,
  output logic                final_key,
  output logic                keys_dropped
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MERGE,
    ST_EMIT_SETUP,
    ST_EMIT
  } state_t;

  state_t state;

  key_t  key_store     [MAX_KEYS];   // bank 0, also the load target
  key_t  merge_scratch [MAX_KEYS];   // bank 1
  key_t  key_a;
  key_t  key_b;

  cnt_t  n;
  logic  ovf;
  logic  src_sel;
  span_t w;
  span_t lo;
  span_t mid;
  span_t hi;
  span_t ia;
  span_t ib;
  span_t wr;
  span_t e;

  span_t n_s;
  span_t w2;
  span_t seg_mid;
  span_t seg_hi;
  span_t ia_next;
  span_t ib_next;
  span_t wr_inc;
  span_t e_inc;
  span_t addr_a;
  span_t addr_b;
  cnt_t  load_slot;
  logic  take_a;
  logic  emit_load;
  logic  we;
  logic  wsel;
  addr_t waddr;
  key_t  wdata;

  always_comb begin
    n_s     = SPAN_W'(n);
    w2      = w << 1;
    seg_mid = ((lo + w) < n_s) ? lo + w : n_s;
    seg_hi  = ((lo + w2) < n_s) ? lo + w2 : n_s;
    // equal keys take the right run first
    take_a  = (ia < mid) && ((ib >= hi) || (key_a < key_b));
    ia_next = take_a ? ia + SPAN_W'(1) : ia;
    ib_next = take_a ? ib : ib + SPAN_W'(1);
    wr_inc  = wr + SPAN_W'(1);
    e_inc   = e + SPAN_W'(1);
    emit_load = !result_valid || result_ready;
    load_slot = q_entry.cnt - CNT_W'(1);
    q_ready = (state == ST_LOAD);

    addr_a = ia;
    addr_b = ib;
    case (state)
      ST_SETUP: begin
        addr_a = lo;
        addr_b = seg_mid;
      end
      ST_MERGE: begin
        addr_a = ia_next;
        addr_b = ib_next;
      end
      ST_EMIT_SETUP: begin
        addr_a = '0;
      end
      ST_EMIT: begin
        addr_a = emit_load ? e_inc : e;
      end
      default: begin
        addr_a = ia;
        addr_b = ib;
      end
    endcase

    we    = 1'b0;
    wsel  = 1'b0;
    waddr = load_slot[ADDR_W-1:0];
    wdata = q_entry.key;
    if (state == ST_LOAD) begin
      we = q_valid && q_entry.store;
    end else if (state == ST_MERGE) begin
      we    = 1'b1;
      wsel  = ~src_sel;
      waddr = wr[ADDR_W-1:0];
      wdata = take_a ? key_a : key_b;
    end
  end

  // banks: one write, two registered reads each
  always_ff @(posedge clk) begin
    if (we) begin
      if (wsel) merge_scratch[waddr] <= wdata;
      else      key_store[waddr]     <= wdata;
    end
    key_a <= src_sel ? merge_scratch[addr_a[ADDR_W-1:0]] : key_store[addr_a[ADDR_W-1:0]];
    key_b <= src_sel ? merge_scratch[addr_b[ADDR_W-1:0]] : key_store[addr_b[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      result_valid <= 1'b0;
      src_sel      <= 1'b0;
    end else begin
      // while streaming, the emit arm below owns the valid flag
      if (result_ready && state != ST_EMIT) result_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (q_valid && q_entry.last) begin
            n       <= q_entry.cnt;
            ovf     <= q_entry.dropped;
            src_sel <= 1'b0;
            w       <= SPAN_W'(1);
            lo      <= '0;
            state   <= (q_entry.cnt == CNT_W'(1)) ? ST_EMIT_SETUP : ST_SETUP;
          end
        end
        ST_SETUP: begin
          mid   <= seg_mid;
          hi    <= seg_hi;
          ia    <= lo;
          ib    <= seg_mid;
          wr    <= lo;
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          ia <= ia_next;
          ib <= ib_next;
          wr <= wr_inc;
          if (wr_inc == hi) begin
            if (hi == n_s) begin
              w       <= w2;
              src_sel <= ~src_sel;
              lo      <= '0;
              state   <= (w2 >= n_s) ? ST_EMIT_SETUP : ST_SETUP;
            end else begin
              lo    <= hi;
              state <= ST_SETUP;
            end
          end
        end
        ST_EMIT_SETUP: begin
          e     <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            result_valid <= 1'b1;
            sorted_key   <= give_key(key_a);
            final_key    <= (e_inc == n_s);
            keys_dropped <= ovf;
            e            <= e_inc;
            if (e_inc == n_s) begin
              src_sel <= 1'b0;
              state   <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // merge bookkeeping: every key written came from exactly one run
  a_merge_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |-> (ia + ib == wr + mid) && (ia <= mid) && (ib <= hi))
    else $error("merge indices out of step");

  a_merge_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |-> wr < hi)
    else $error("merge write past segment end");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> e < n_s)
    else $error("emit index past run length");

endmodule

>>> design/merge_sorter.sv
// Sorting: the sort takes ceil(log2 n) merge passes, each moving all n keys and opening
//   every merge segment with a set-up state.
// Throughput: keys load at 1 per cycle while the queue has room; results leave at 1 per cycle
//   while result_ready allows; the merge engine moves one key per cycle; load, passes and
//   emit run in turn.
// Reset: synchronous, active high; clears counters, queue and state, not the key banks.
// ----------------------------------------------------------------------------
// merge_sorter: ascending merge sort of a run of unsigned keys
// Front classifies items, a four-entry queue decouples it from the back end,
// which stores, sorts and streams the run out in ascending order.
// ----------------------------------------------------------------------------
//
// Structure
//   ms_front : counts keys in the open run and gives each item its store
//              slot; once the store is full further keys are dropped and
//              the overflow mark rides along with every later item.
//   ms_queue : short FIFO of classified items. The front keeps taking keys
//              while the back is busy sorting, until the queue fills.
//   ms_back  : two key banks. Keys load into the first; a bottom-up merge
//              ping-pongs between the banks, widths 1, 2, 4, ... until one
//              run covers all n keys. Each merge step reads both run heads
//              (registered reads whose addresses are issued ahead) and writes one key.
//              A set-up state opens each segment. The sorted bank then
//              streams through an output register, one item per cycle while
//              result_ready allows, with the final item flagged.
//
// Only the keys of the current run are ever read, so the banks need no
// clearing after reset.
module merge_sorter
  import ms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                key_valid,
  output logic                key_ready,
  input  logic [IN_BITS-1:0]  key_value,
  input  logic                run_end,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [OUT_BITS-1:0] sorted_key,
  output logic                final_key,
  output logic                keys_dropped
);

  // front to queue
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;

  // queue to back
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  ms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .key_value  (key_value),
    .run_end    (run_end),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // back end takes queue items only while loading; sorting and streaming
  // leave them waiting in the queue
  ms_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (pop_valid),
    .q_ready      (pop_ready),
    .q_entry      (pop_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sorted_key   (sorted_key),
    .final_key    (final_key),
    .keys_dropped (keys_dropped)
  );

endmodule
